[rtl/core/urfc_pkg.sv]
// types and constants for the uart receive fifo with flow control
package urfc_pkg;

	typedef enum logic [1:0] {
		KIND_NONE      = 2'd0,
		KIND_DATA      = 2'd1,
		KIND_BREAK     = 2'd2,
		KIND_BREAK_IGN = 2'd3
	} out_kind_t;

	typedef enum logic [2:0] {
		REG_XON_ENABLE      = 3'd0,
		REG_ANY_RESUME      = 3'd1,
		REG_IGNORE_BREAK    = 3'd2,
		REG_BREAK_INTERRUPT = 3'd3,
		REG_STRIP_HIGH_BIT  = 3'd4,
		REG_NO_FLUSH        = 3'd5,
		REG_START_CHAR      = 3'd6,
		REG_STOP_CHAR       = 3'd7
	} cfg_reg_t;

	localparam int unsigned WORD_W     = 9;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned OUT_DATA_W = 24;

	localparam logic [CHAR_W-1:0] START_CHAR_RST = 8'h11;
	localparam logic [CHAR_W-1:0] STOP_CHAR_RST  = 8'h13;
	localparam logic [CHAR_W-1:0] SEVEN_BIT_MASK = 8'h7f;

	typedef struct packed {
		logic [CHAR_W-1:0] fill_level;
		logic              peer_xoff;
		logic              rts_off;
		logic              rx_dropped;
		logic              want_flush;
		logic              want_sigint;
		logic [CHAR_W-1:0] out_byte;
	} result_t;

endpackage

[rtl/core/uart_rx_flow_control_fifo.sv]
// uart receive fifo with xon/xoff and rts flow control
//
// usage:
//   s_tuser selects the request: 0 pushes the line word in s_tdata (data in
//   bits 7..0, stop bit in bit 8), 1 pops the oldest stored word. every
//   accepted beat yields exactly one result beat on the master side, with the
//   result kind in m_tuser and the popped byte, break requests, drop flag,
//   rts state, peer xoff flag and fill level in m_tdata.
//   the result of an accepted beat is registered and presented from the edge
//   that accepts it. one beat is accepted per cycle unless the output stalls;
//   the head word of the fifo is kept in a register that the storage array
//   refills on every edge, so back-to-back pops run at full rate.
//   the configuration port writes one register per cycle with cfg_we high.
//   the user must use it only while no beat is in flight; the block does not enforce this.
//   reset clears the pointers and fill count, enables receive, turns rts on
//   and loads the default start and stop characters. the storage array is
//   not cleared and needs no clearing pass.
//   while the result register is full and m_tready is low, s_tready is low
//   and the block holds its state.
module uart_rx_flow_control_fifo #(
	parameter int DEPTH      = 256,
	parameter int LOW_WATER  = 32,
	parameter int HIGH_WATER = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_addr,
	input  logic [7:0]                          cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [urfc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [8:0] rx_word
	input  logic                                s_tuser,   // [0] req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [urfc_pkg::OUT_DATA_W-1:0]     m_tdata,   // [7:0] out_byte, [8] want_sigint,
	                                                       // [9] want_flush, [10] rx_dropped,
	                                                       // [11] rts_off, [12] peer_xoff,
	                                                       // [20:13] fill_level
	output logic [1:0]                          m_tuser    // [1:0] out_kind
);
	import urfc_pkg::*;

	localparam int AW          = $clog2(DEPTH);
	localparam int FW          = (AW > 8) ? AW : 8;
	localparam bit RTS_ALWAYS  = (DEPTH - LOW_WATER) < 0;
	localparam int RTS_LVL     = RTS_ALWAYS ? 0 : (DEPTH - LOW_WATER);
	localparam bit RLS_NEVER   = (DEPTH - HIGH_WATER) <= 0;
	localparam int RLS_LVL     = RLS_NEVER ? 0 : (DEPTH - HIGH_WATER);

	logic [WORD_W-1:0] mem [DEPTH];

	logic              xon_enable_q, any_resume_q, ignore_break_q;
	logic              break_interrupt_q, strip_high_bit_q, no_flush_q;
	logic [CHAR_W-1:0] start_char_q, stop_char_q;

	logic [AW-1:0]     wp_q, rp_q, count_q;
	logic              xoff_q, rx_en_q, rts_q;
	logic [WORD_W-1:0] head_q;

	logic              out_valid_q;
	result_t           out_res_q;
	out_kind_t         out_kind_q;

	logic              take;
	logic              is_pop;
	logic [WORD_W-1:0] word;
	logic              store, pop_go;
	logic [AW-1:0]     wp_inc, rp_inc, rd_addr;
	logic [AW-1:0]     count_nxt;
	logic              xoff_nxt, rx_en_nxt, rts_nxt, dropped;
	out_kind_t         kind;
	logic [CHAR_W-1:0] byte_val;
	logic              sigint, flush;
	logic [FW-1:0]     fill_ext;
	result_t           res;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign is_pop   = s_tuser;
	assign word     = s_tdata[WORD_W-1:0];

	assign wp_inc = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;

	always_comb begin
		store     = 1'b0;
		pop_go    = 1'b0;
		count_nxt = count_q;
		xoff_nxt  = xoff_q;
		rx_en_nxt = rx_en_q;
		rts_nxt   = rts_q;
		dropped   = 1'b0;
		kind      = KIND_NONE;
		byte_val  = '0;
		sigint    = 1'b0;
		flush     = 1'b0;
		if (take && !is_pop) begin
			if (!rx_en_q) begin
				dropped = 1'b1;
			end else if (xon_enable_q && word == {1'b1, start_char_q}) begin
				xoff_nxt = 1'b0;
			end else if (xon_enable_q && word == {1'b1, stop_char_q}) begin
				xoff_nxt = 1'b1;
			end else begin
				if (xon_enable_q && any_resume_q)
					xoff_nxt = 1'b0;
				if (count_q == AW'(DEPTH - 1)) begin
					rx_en_nxt = 1'b0;
					dropped   = 1'b1;
				end else begin
					if (RTS_ALWAYS || ({1'b0, count_q} > (AW+1)'(RTS_LVL)))
						rts_nxt = 1'b1;
					store     = 1'b1;
					count_nxt = count_q + 1'b1;
				end
			end
		end else if (take && is_pop && count_q != '0) begin
			pop_go    = 1'b1;
			count_nxt = count_q - 1'b1;
			if (head_q == '0 && ignore_break_q) begin
				kind = KIND_BREAK_IGN;
			end else begin
				if (head_q == '0) begin
					kind   = KIND_BREAK;
					flush  = !no_flush_q;
					sigint = break_interrupt_q;
				end else begin
					kind     = KIND_DATA;
					byte_val = head_q[CHAR_W-1:0];
					if (strip_high_bit_q)
						byte_val = byte_val & SEVEN_BIT_MASK;
				end
				rx_en_nxt = 1'b1;
				if (!RLS_NEVER && ({1'b0, count_nxt} < (AW+1)'(RLS_LVL)))
					rts_nxt = 1'b0;
			end
		end
	end

	assign rd_addr  = pop_go ? rp_inc : rp_q;
	assign fill_ext = FW'(count_nxt);

	always_comb begin
		res.fill_level  = fill_ext[7:0];
		res.peer_xoff   = xoff_nxt;
		res.rts_off     = rts_nxt;
		res.rx_dropped  = dropped;
		res.want_flush  = flush;
		res.want_sigint = sigint;
		res.out_byte    = byte_val;
	end

	// storage array and head word register
	always_ff @(posedge clk) begin
		if (store)
			mem[wp_q] <= word;
		if (store && wp_q == rd_addr)
			head_q <= word;
		else
			head_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xon_enable_q      <= 1'b0;
			any_resume_q      <= 1'b0;
			ignore_break_q    <= 1'b0;
			break_interrupt_q <= 1'b0;
			strip_high_bit_q  <= 1'b0;
			no_flush_q        <= 1'b0;
			start_char_q      <= START_CHAR_RST;
			stop_char_q       <= STOP_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_XON_ENABLE:      xon_enable_q      <= cfg_data[0];
				REG_ANY_RESUME:      any_resume_q      <= cfg_data[0];
				REG_IGNORE_BREAK:    ignore_break_q    <= cfg_data[0];
				REG_BREAK_INTERRUPT: break_interrupt_q <= cfg_data[0];
				REG_STRIP_HIGH_BIT:  strip_high_bit_q  <= cfg_data[0];
				REG_NO_FLUSH:        no_flush_q        <= cfg_data[0];
				REG_START_CHAR:      start_char_q      <= cfg_data;
				REG_STOP_CHAR:       stop_char_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
			xoff_q  <= 1'b0;
			rx_en_q <= 1'b1;
			rts_q   <= 1'b0;
		end else if (take) begin
			if (store)
				wp_q <= wp_inc;
			if (pop_go)
				rp_q <= rp_inc;
			count_q <= count_nxt;
			xoff_q  <= xoff_nxt;
			rx_en_q <= rx_en_nxt;
			rts_q   <= rts_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s_tready)
			out_valid_q <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_res_q  <= res;
			out_kind_q <= kind;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_res_q};
	assign m_tuser  = out_kind_q;

	// checks
	logic [AW:0] ptr_sum;
	logic [AW-1:0] wp_chk;
	assign ptr_sum = {1'b0, rp_q} + {1'b0, count_q};
	assign wp_chk  = (ptr_sum >= (AW+1)'(DEPTH)) ? AW'(ptr_sum - (AW+1)'(DEPTH))
	                                             : ptr_sum[AW-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= AW'(DEPTH - 1))
		else $error("fill count above capacity");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == wp_chk)
		else $error("write pointer out of step with read pointer and count");

	a_drop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		take && !is_pop && dropped |=> $stable(count_q) && !rx_en_q)
		else $error("dropped word changed fill or left receive enabled");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		take && is_pop && count_q == '0 |=> m_tuser == KIND_NONE && $stable(rp_q))
		else $error("pop from empty fifo returned a word");

endmodule
